/* hdl/bblru_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bblru_pkg
// Shared constants, request codes and controller/datapath structs for the
// byte budget LRU directory.
// ----------------------------------------------------------------------------
package bblru_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int KEY_BITS_DEF = 32;

    localparam int KEY_W  = 32;
    localparam int DIM_W  = 11;
    localparam int SIZE_W = 2 * DIM_W + 2;
    localparam int CAP_W  = 32;
    localparam int TOT_W  = 33;
    localparam int CNT_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 32'd67108864;

    localparam logic [1:0] REQ_LOOKUP = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef struct packed {
        logic start;
        logic clear;
        logic scan;
        logic rd_found;
        logic rd_oldest;
        logic detach;
        logic drop;
        logic attach_mv;
        logic place;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic found_newest;
        logic over;
        logic full;
        logic is_lookup;
        logic free_vld;
    } t_sts;

endpackage
`default_nettype wire

/* hdl/bblru_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bblru_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bblru_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [bblru_pkg::KEY_W-1:0]  key;
    logic [bblru_pkg::DIM_W-1:0]  width;
    logic [bblru_pkg::DIM_W-1:0]  height;

    modport source (output valid, req_type, key, width, height, input ready);
    modport sink   (input valid, req_type, key, width, height, output ready);
endinterface

interface bblru_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [bblru_pkg::CNT_W-1:0]  evicted;
    logic [bblru_pkg::TOT_W-1:0]  total_bytes;
    logic [bblru_pkg::CNT_W-1:0]  entry_count;

    modport source (output valid, hit, evicted, total_bytes, entry_count, input ready);
    modport sink   (input valid, hit, evicted, total_bytes, entry_count, output ready);
endinterface
`default_nettype wire

/* hdl/bblru_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bblru_ctrl
// Sequencer: scan, eviction loop, relink and place steps, response word.
// ----------------------------------------------------------------------------
module bblru_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [1:0]        i_req_type,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire bblru_pkg::t_sts   i_sts,
    output bblru_pkg::t_cmd        o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SCAN  = 13'b0000000000010,
        S_DEC   = 13'b0000000000100,
        S_RDF   = 13'b0000000001000,
        S_RDO   = 13'b0000000010000,
        S_RDOL  = 13'b0000000100000,
        S_DROP  = 13'b0000001000000,
        S_DROPL = 13'b0000010000000,
        S_MVDET = 13'b0000100000000,
        S_MVATT = 13'b0001000000000,
        S_EVCHK = 13'b0010000000000,
        S_PLACE = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_vld, n_out_vld;

    always_comb begin
        n_state   = r_state;
        n_out_vld = r_out_vld;
        o_cmd     = '0;
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    if (i_req_type == bblru_pkg::REQ_CLEAR) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FIN;
                    end else if (i_req_type == bblru_pkg::REQ_LOOKUP ||
                                 i_req_type == bblru_pkg::REQ_INSERT) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.is_lookup) begin
                    n_state = (i_sts.found && !i_sts.found_newest) ? S_RDF : S_FIN;
                end else begin
                    n_state = i_sts.found ? S_RDF : S_EVCHK;
                end
            end
            S_RDF: begin
                o_cmd.rd_found = 1'b1;
                n_state = i_sts.is_lookup ? S_MVDET : S_DROP;
            end
            S_RDO: begin
                o_cmd.rd_oldest = 1'b1;
                n_state = S_DROP;
            end
            S_RDOL: begin
                o_cmd.rd_oldest = 1'b1;
                n_state = S_DROPL;
            end
            S_DROP: begin
                o_cmd.detach = 1'b1;
                o_cmd.drop   = 1'b1;
                n_state = S_EVCHK;
            end
            S_DROPL: begin
                o_cmd.detach = 1'b1;
                o_cmd.drop   = 1'b1;
                n_state = S_PLACE;
            end
            S_MVDET: begin
                o_cmd.detach = 1'b1;
                n_state = S_MVATT;
            end
            S_MVATT: begin
                o_cmd.attach_mv = 1'b1;
                n_state = S_FIN;
            end
            S_EVCHK: begin
                priority if (i_sts.over) begin
                    n_state = S_RDO;
                end else if (i_sts.full) begin
                    n_state = S_RDOL;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_vld      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule
`default_nettype wire

/* hdl/bblru_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bblru_dp
// Entry stores, recency links, valid marks, totals and response registers.
// ----------------------------------------------------------------------------
module bblru_dp #(
    parameter int ENTRIES  = bblru_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = bblru_pkg::KEY_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bblru_pkg::CAP_W-1:0]   i_cfg_wdata,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [bblru_pkg::KEY_W-1:0]   i_key,
    input  wire logic [bblru_pkg::DIM_W-1:0]   i_width,
    input  wire logic [bblru_pkg::DIM_W-1:0]   i_height,
    input  wire bblru_pkg::t_cmd               i_cmd,
    output bblru_pkg::t_sts                    o_sts,
    output logic                               o_hit,
    output logic [bblru_pkg::CNT_W-1:0]        o_evicted,
    output logic [bblru_pkg::TOT_W-1:0]        o_total_bytes,
    output logic [bblru_pkg::CNT_W-1:0]        o_entry_count
);

    localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int SIZE_W = bblru_pkg::SIZE_W;
    localparam int TOT_W  = bblru_pkg::TOT_W;
    localparam int CNT_W  = bblru_pkg::CNT_W;
    localparam int CAP_W  = bblru_pkg::CAP_W;
    localparam int AREA_W = 2 * bblru_pkg::DIM_W;
    localparam logic [CW-1:0] NUM = CW'(ENTRIES);

    logic [KEY_BITS-1:0] key_mem   [ENTRIES];
    logic [SIZE_W-1:0]   size_mem  [ENTRIES];
    logic [IW-1:0]       older_mem [ENTRIES];
    logic [IW-1:0]       newer_mem [ENTRIES];

    logic [KEY_BITS-1:0] r_key_rd;
    logic [SIZE_W-1:0]   r_size_rd;
    logic [IW-1:0]       r_older_rd, r_newer_rd;

    logic [1:0]          r_req, n_req;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [CAP_W-1:0]    r_cap;
    logic [ENTRIES-1:0]  r_valid, n_valid;
    logic [IW-1:0]       r_newest, n_newest, r_oldest, n_oldest;
    logic [CW-1:0]       r_count, n_count;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [CW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_cmp_idx, n_cmp_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_found, n_found;
    logic [IW-1:0]       r_found_slot, n_found_slot;
    logic                r_free_vld, n_free_vld;
    logic [IW-1:0]       r_free, n_free;
    logic [IW-1:0]       r_rm_slot, n_rm_slot;
    logic [CW-1:0]       r_evicted, n_evicted;

    logic                r_o_hit;
    logic [CNT_W-1:0]    r_o_evicted, r_o_count;
    logic [TOT_W-1:0]    r_o_total;

    logic [AREA_W-1:0]   area;
    logic [IW-1:0]       scan_a, rd_addr;
    logic                scan_live;
    logic                kv_we;
    logic                old_we, new_we;
    logic [IW-1:0]       old_wa, old_wd, new_wa, new_wd;

    assign area      = AREA_W'(i_width) * AREA_W'(i_height);
    assign scan_live = (r_idx < NUM);
    assign scan_a    = scan_live ? r_idx[IW-1:0] : '0;

    always_comb begin
        priority if (i_cmd.scan) begin
            rd_addr = scan_a;
        end else if (i_cmd.rd_found) begin
            rd_addr = r_found_slot;
        end else begin
            rd_addr = r_oldest;
        end
    end

    always_comb begin
        n_req        = r_req;
        n_key        = r_key;
        n_size       = r_size;
        n_valid      = r_valid;
        n_newest     = r_newest;
        n_oldest     = r_oldest;
        n_count      = r_count;
        n_total      = r_total;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_vld    = 1'b0;
        n_found      = r_found;
        n_found_slot = r_found_slot;
        n_free_vld   = r_free_vld;
        n_free       = r_free;
        n_rm_slot    = r_rm_slot;
        n_evicted    = r_evicted;
        kv_we        = 1'b0;
        old_we       = 1'b0;
        old_wa       = '0;
        old_wd       = '0;
        new_we       = 1'b0;
        new_wa       = '0;
        new_wd       = '0;

        if (i_cmd.start) begin
            n_req      = i_req_type;
            n_key      = KEY_BITS'(i_key);
            n_size     = {area, 2'b00};
            n_idx      = '0;
            n_found    = 1'b0;
            n_free_vld = 1'b0;
            n_evicted  = '0;
        end
        if (i_cmd.clear) begin
            n_valid  = '0;
            n_count  = '0;
            n_total  = '0;
            n_newest = '0;
            n_oldest = '0;
        end

        if (i_cmd.scan && scan_live) begin
            n_idx     = r_idx + 1'b1;
            n_cmp_vld = 1'b1;
            n_cmp_idx = scan_a;
            if (!r_valid[scan_a] && !r_free_vld) begin
                n_free_vld = 1'b1;
                n_free     = scan_a;
            end
        end
        if (r_cmp_vld && r_valid[r_cmp_idx] && (r_key_rd == r_key) && !r_found) begin
            n_found      = 1'b1;
            n_found_slot = r_cmp_idx;
        end

        if (i_cmd.rd_found) begin
            n_rm_slot = r_found_slot;
        end
        if (i_cmd.rd_oldest) begin
            n_rm_slot = r_oldest;
        end

        if (i_cmd.detach && (r_count > CW'(1))) begin
            priority if (r_rm_slot == r_newest) begin
                n_newest = r_older_rd;
            end else if (r_rm_slot == r_oldest) begin
                n_oldest = r_newer_rd;
            end else begin
                new_we = 1'b1;
                new_wa = r_older_rd;
                new_wd = r_newer_rd;
                old_we = 1'b1;
                old_wa = r_newer_rd;
                old_wd = r_older_rd;
            end
        end
        if (i_cmd.drop) begin
            n_valid[r_rm_slot] = 1'b0;
            n_count   = r_count - 1'b1;
            n_total   = r_total - TOT_W'(r_size_rd);
            n_evicted = r_evicted + 1'b1;
            if (!r_free_vld || (r_rm_slot < r_free)) begin
                n_free_vld = 1'b1;
                n_free     = r_rm_slot;
            end
        end

        if (i_cmd.attach_mv) begin
            old_we   = 1'b1;
            old_wa   = r_rm_slot;
            old_wd   = r_newest;
            new_we   = 1'b1;
            new_wa   = r_newest;
            new_wd   = r_rm_slot;
            n_newest = r_rm_slot;
        end

        if (i_cmd.place) begin
            kv_we           = 1'b1;
            n_valid[r_free] = 1'b1;
            n_newest        = r_free;
            n_count         = r_count + 1'b1;
            n_total         = r_total + TOT_W'(r_size);
            if (r_count == '0) begin
                n_oldest = r_free;
            end else begin
                old_we = 1'b1;
                old_wa = r_free;
                old_wd = r_newest;
                new_we = 1'b1;
                new_wa = r_newest;
                new_wd = r_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            key_mem[r_free]  <= r_key;
            size_mem[r_free] <= r_size;
        end
        if (old_we) begin
            older_mem[old_wa] <= old_wd;
        end
        if (new_we) begin
            newer_mem[new_wa] <= new_wd;
        end
        r_key_rd   <= key_mem[rd_addr];
        r_size_rd  <= size_mem[rd_addr];
        r_older_rd <= older_mem[rd_addr];
        r_newer_rd <= newer_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= bblru_pkg::CAP_RESET;
            r_valid   <= '0;
            r_newest  <= '0;
            r_oldest  <= '0;
            r_count   <= '0;
            r_total   <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_free_vld <= 1'b0;
            r_evicted <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_valid    <= n_valid;
            r_newest   <= n_newest;
            r_oldest   <= n_oldest;
            r_count    <= n_count;
            r_total    <= n_total;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_found    <= n_found;
            r_free_vld <= n_free_vld;
            r_evicted  <= n_evicted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_key        <= n_key;
        r_size       <= n_size;
        r_cmp_idx    <= n_cmp_idx;
        r_found_slot <= n_found_slot;
        r_free       <= n_free;
        r_rm_slot    <= n_rm_slot;
        if (i_cmd.load_out) begin
            r_o_hit     <= (r_req == bblru_pkg::REQ_LOOKUP) && r_found;
            r_o_evicted <= CNT_W'(r_evicted);
            r_o_total   <= r_total;
            r_o_count   <= CNT_W'(r_count);
        end
    end

    assign o_sts.scan_done    = (r_idx == NUM);
    assign o_sts.found        = r_found;
    assign o_sts.found_newest = (r_found_slot == r_newest);
    assign o_sts.over         = (r_count != '0) &&
                                (({1'b0, r_total} + (TOT_W + 1)'(r_size)) >
                                 (TOT_W + 1)'(r_cap));
    assign o_sts.full         = (r_count >= NUM);
    assign o_sts.is_lookup    = (r_req == bblru_pkg::REQ_LOOKUP);
    assign o_sts.free_vld     = r_free_vld;

    assign o_hit         = r_o_hit;
    assign o_evicted     = r_o_evicted;
    assign o_total_bytes = r_o_total;
    assign o_entry_count = r_o_count;

endmodule
`default_nettype wire

/* hdl/byte_budget_lru_directory_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// byte_budget_lru_directory_unit
// LRU directory of keyed entries with sizes counted against a byte budget.
// ----------------------------------------------------------------------------
//  channel   dir  word
//  i_req     in   req_type, key, width, height
//  o_rsp     out  hit, evicted, total_bytes, entry_count
//  i_cfg_*   in   capacity_bytes, written when i_cfg_we is high
//
//  Lookup and insert scan the key store one slot a cycle; a lookup hit not yet
//  newest is moved to the newest end. An insert checks budget and table, then
//  places, reading and dropping an entry per same-key, budget or full-table
//  eviction. Clear and unused codes do not scan. One word is processed at a time.
//  Reset is synchronous; entries become empty at once, no clearing pass.
//  A finished response waits in its output register while the next word is taken.
// ----------------------------------------------------------------------------
module byte_budget_lru_directory_unit #(
    parameter int ENTRIES  = bblru_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = bblru_pkg::KEY_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [bblru_pkg::CAP_W-1:0]  i_cfg_wdata,
    bblru_req_if.sink                         i_req,
    bblru_rsp_if.source                       o_rsp
);

    bblru_pkg::t_cmd cmd;
    bblru_pkg::t_sts sts;

    bblru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_req_type  (i_req.req_type),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bblru_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req.req_type),
        .i_key         (i_req.key),
        .i_width       (i_req.width),
        .i_height      (i_req.height),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_hit         (o_rsp.hit),
        .o_evicted     (o_rsp.evicted),
        .o_total_bytes (o_rsp.total_bytes),
        .o_entry_count (o_rsp.entry_count)
    );

    a_place_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.place |-> sts.free_vld)
        else $error("place without a free slot");

    a_place_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.place |-> !sts.full)
        else $error("place into a full table");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> !(o_rsp.valid && !o_rsp.ready))
        else $error("response overwritten before taken");

    a_rd_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_found |-> sts.found)
        else $error("found slot read without a match");

endmodule
`default_nettype wire

/* tb/sv/tb_byte_budget_lru_directory_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_budget_lru_directory_unit
// Drives lookup, insert, clear and unused-code words through the request
// channel under several byte budgets, predicts every response from a
// recency-ordered copy of the directory and checks each response field.
// ----------------------------------------------------------------------------
module tb_byte_budget_lru_directory_unit;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         DIR_DEPTH  = bblru_pkg::ENTRIES_DEF;
    localparam int         DRAIN_CYC  = 3 * DIR_DEPTH + 40;
    localparam int         CYCLE_LIMIT = 3_000_000;
    localparam int         KEY_W = bblru_pkg::KEY_W;
    localparam int         DIM_W = bblru_pkg::DIM_W;
    localparam int         CNT_W = bblru_pkg::CNT_W;
    localparam int         TOT_W = bblru_pkg::TOT_W;
    localparam int         CAP_W = bblru_pkg::CAP_W;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_dir_word;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] evicted;
        logic [TOT_W-1:0] total;
        logic [CNT_W-1:0] count;
    } t_dir_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata = '0;

    bblru_req_if req_if ();
    bblru_rsp_if rsp_if ();

    byte_budget_lru_directory_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always #1 i_clk = ~i_clk;

    t_dir_word       pending_words[$];
    t_dir_rsp        expected_rsps[$];
    logic [KEY_W-1:0] lru_keys[$];
    logic [23:0]     lru_sizes[$];
    logic [CAP_W-1:0] budget = bblru_pkg::CAP_RESET;
    logic [TOT_W-1:0] resident_bytes = '0;
    logic [KEY_W-1:0] key_pool[80];
    bit              no_idle = 1'b0;
    int              err_cnt = 0;
    int              cycles = 0;

    function automatic void drop_lru(int idx);
        resident_bytes -= TOT_W'(lru_sizes[idx]);
        lru_keys.delete(idx);
        lru_sizes.delete(idx);
    endfunction

    function automatic t_dir_rsp directory_update(t_dir_word wd);
        t_dir_rsp r;
        int found;
        logic [31:0] sz;
        logic [KEY_W-1:0] k;
        logic [23:0] s;
        r = '0;
        found = -1;
        foreach (lru_keys[i]) if (lru_keys[i] == wd.key) found = i;
        case (wd.op)
            bblru_pkg::REQ_LOOKUP: begin
                if (found >= 0) begin
                    r.hit = 1'b1;
                    k = lru_keys[found];
                    s = lru_sizes[found];
                    lru_keys.delete(found);
                    lru_sizes.delete(found);
                    lru_keys.push_back(k);
                    lru_sizes.push_back(s);
                end
            end
            bblru_pkg::REQ_INSERT: begin
                sz = 32'(wd.w) * 32'(wd.h) * 32'd4;
                if (found >= 0) begin
                    drop_lru(found);
                    r.evicted++;
                end
                while (lru_keys.size() > 0 &&
                       64'(resident_bytes) + 64'(sz) > 64'(budget)) begin
                    drop_lru(0);
                    r.evicted++;
                end
                if (lru_keys.size() >= DIR_DEPTH) begin
                    drop_lru(0);
                    r.evicted++;
                end
                lru_keys.push_back(wd.key);
                lru_sizes.push_back(sz[23:0]);
                resident_bytes += TOT_W'(sz);
            end
            bblru_pkg::REQ_CLEAR: begin
                lru_keys.delete();
                lru_sizes.delete();
                resident_bytes = '0;
            end
            default: ;
        endcase
        r.total = resident_bytes;
        r.count = CNT_W'(lru_keys.size());
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                expected_rsps.push_back(directory_update(
                    {req_if.req_type, req_if.key, req_if.width, req_if.height}));
            if (!req_if.valid || req_if.ready) begin
                if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 24)) begin
                    t_dir_word wd;
                    wd = pending_words.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.req_type <= wd.op;
                    req_if.key      <= wd.key;
                    req_if.width    <= wd.w;
                    req_if.height   <= wd.h;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        rsp_if.ready <= no_idle || ($urandom_range(99) >= 24);
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                $error("unexpected response word");
                err_cnt++;
            end else begin
                t_dir_rsp e;
                e = expected_rsps.pop_front();
                if (rsp_if.hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, rsp_if.hit);
                    err_cnt++;
                end
                if (rsp_if.evicted !== e.evicted) begin
                    $error("evicted exp %0d got %0d", e.evicted, rsp_if.evicted);
                    err_cnt++;
                end
                if (rsp_if.total_bytes !== e.total) begin
                    $error("total_bytes exp %0d got %0d", e.total, rsp_if.total_bytes);
                    err_cnt++;
                end
                if (rsp_if.entry_count !== e.count) begin
                    $error("entry_count exp %0d got %0d", e.count, rsp_if.entry_count);
                    err_cnt++;
                end
            end
        end
    end

    task automatic push_word(logic [1:0] op, logic [KEY_W-1:0] k,
                             logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        pending_words.push_back({op, k, w, h});
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [CAP_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        budget = v;
    endtask

    task automatic random_words(int n);
        int r;
        logic [DIM_W-1:0] w, h;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if ($urandom_range(9) == 0) begin
                w = DIM_W'($urandom);
                h = DIM_W'($urandom);
            end else begin
                w = DIM_W'($urandom_range(63));
                h = DIM_W'($urandom_range(63));
            end
            if (r < 45)
                push_word(bblru_pkg::REQ_LOOKUP, key_pool[$urandom_range(79)], w, h);
            else if (r < 86)
                push_word(bblru_pkg::REQ_INSERT, key_pool[$urandom_range(79)], w, h);
            else if (r < 88)
                push_word(bblru_pkg::REQ_CLEAR, KEY_W'($urandom), w, h);
            else if (r < 90)
                push_word(REQ_UNUSED, KEY_W'($urandom), w, h);
            else
                push_word(2'($urandom_range(1)), KEY_W'($urandom), w, h);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] budgets[5];
        req_if.valid = 1'b0;
        req_if.req_type = bblru_pkg::REQ_LOOKUP;
        req_if.key = '0;
        req_if.width = '0;
        req_if.height = '0;
        rsp_if.ready = 1'b0;
        foreach (key_pool[i]) key_pool[i] = (i < 2) ? {KEY_W{i[0]}} : KEY_W'($urandom);
        budgets = '{32'hFFFF_FFFF, 32'd0, 32'd200000, 32'd8000000, bblru_pkg::CAP_RESET};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset budget
        push_word(bblru_pkg::REQ_LOOKUP, 32'h0, '0, '0);
        push_word(bblru_pkg::REQ_INSERT, 32'h0, '0, '0);
        push_word(bblru_pkg::REQ_INSERT, 32'hFFFF_FFFF, DIM_W'(2047), DIM_W'(2047));
        push_word(bblru_pkg::REQ_INSERT, 32'h1234_5678, DIM_W'(2047), DIM_W'(2047));
        push_word(bblru_pkg::REQ_LOOKUP, 32'h0, '0, '0);
        push_word(bblru_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, '0, '0);
        push_word(bblru_pkg::REQ_LOOKUP, 32'hDEAD_BEEF, '0, '0);
        push_word(bblru_pkg::REQ_INSERT, 32'h1234_5678, DIM_W'(1000), DIM_W'(3));
        push_word(bblru_pkg::REQ_INSERT, 32'h5555_AAAA, DIM_W'(2047), DIM_W'(2047));
        push_word(bblru_pkg::REQ_INSERT, 32'h5555_AAAA, DIM_W'(2047), DIM_W'(2047));
        push_word(REQ_UNUSED, 32'hFFFF_FFFF, DIM_W'(2047), DIM_W'(2047));
        push_word(bblru_pkg::REQ_CLEAR, 32'h0, '0, '0);
        push_word(bblru_pkg::REQ_LOOKUP, 32'h1234_5678, '0, '0);
        push_word(bblru_pkg::REQ_INSERT, 32'hAAAA_5555, DIM_W'(1), DIM_W'(1));
        push_word(bblru_pkg::REQ_CLEAR, 32'h0, '0, '0);
        wait_idle();

        // full table under the largest budget, no stalls
        no_idle = 1'b1;
        write_budget(budgets[0]);
        for (int i = 0; i < 70; i++)
            push_word(bblru_pkg::REQ_INSERT, KEY_W'(32'h100 + i),
                      DIM_W'($urandom_range(31)), DIM_W'($urandom_range(31)));
        random_words(250);
        wait_idle();
        no_idle = 1'b0;

        for (int p = 1; p < 5; p++) begin
            write_budget(budgets[p]);
            random_words(400);
            wait_idle();
        end

        repeat (DRAIN_CYC) @(posedge i_clk);
        if (err_cnt == 0 && expected_rsps.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
